FILE: sv/tbmr_pkg.sv
package tbmr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAG_BITS = 15;
  localparam int DIV_W = MAG_BITS + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int RATIO_W = FRAC_BITS + 1;

  localparam logic [15:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam logic [15:0] WAIT_GIVEUP_MS = 16'd50;

  localparam logic [2:0] CFG_ARM_DELAY = 3'd0;
  localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_SCROLL_V = 3'd2;
  localparam logic [2:0] CFG_SCROLL_H = 3'd3;
  localparam logic [2:0] CFG_REC_FRAMES = 3'd4;
  localparam logic [2:0] CFG_REPLAY_RATIO = 3'd5;
  localparam logic [2:0] CFG_LOCK_DIST = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WAITING = 3'd1,
    MODE_CLICKABLE = 3'd2,
    MODE_CLICKING = 3'd3,
    MODE_SCROLLING = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_REC,
    ST_PDIV,
    ST_SCALE,
    ST_STEP,
    ST_QDIV,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic key;
    logic rec;
    logic pfin;
    logic scale;
    logic step;
    logic qfin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_key;
    logic need_pdiv;
    logic need_quant;
    logic div_busy;
    logic out_busy;
  } status_t;

endpackage

FILE: sv/tbmr_div.sv
module tbmr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tbmr_pkg::DIV_CNT_W-1:0]    len,
  input  logic [tbmr_pkg::DIV_W-1:0]        dividend,
  input  logic [tbmr_pkg::MAG_BITS-1:0]     divisor,
  output logic                              busy,
  output logic [tbmr_pkg::DIV_W-1:0]        quotient,
  output logic [tbmr_pkg::MAG_BITS-1:0]     remainder
);

  logic [tbmr_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tbmr_pkg::DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [tbmr_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [tbmr_pkg::MAG_BITS-1:0]  rem_r, rem_nxt;
  logic [tbmr_pkg::MAG_BITS-1:0]  dsr_r, dsr_nxt;
  logic [tbmr_pkg::MAG_BITS:0]    rem_sh;
  logic                           qbit;

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    rem_sh = {rem_r, dvd_r[tbmr_pkg::DIV_W-1]};
    qbit = (rem_sh >= {1'b0, dsr_r});
    if (start) begin
      cnt_nxt = len;
      dvd_nxt = dividend;
      quo_nxt = '0;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = {dvd_r[tbmr_pkg::DIV_W-2:0], 1'b0};
      quo_nxt = {quo_r[tbmr_pkg::DIV_W-2:0], qbit};
      rem_nxt = qbit ? tbmr_pkg::MAG_BITS'(rem_sh - {1'b0, dsr_r})
                     : rem_sh[tbmr_pkg::MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quotient = quo_r;
  assign remainder = rem_r;

endmodule

FILE: sv/tbmr_dp.sv
module tbmr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbmr_pkg::cmd_t       cmd,
  output tbmr_pkg::status_t    sts,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_opcode,
  input  logic signed [7:0]    in_dx,
  input  logic signed [7:0]    in_dy,
  input  logic [2:0]           in_key_kind,
  input  logic                 in_key_pressed,
  input  logic [15:0]          in_now_ms,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic signed [7:0]    out_dx,
  output logic signed [7:0]    out_dy,
  output logic signed [7:0]    out_scroll_h,
  output logic signed [7:0]    out_scroll_v,
  output logic [2:0]           out_buttons,
  output logic                 out_click_layer_active,
  output logic [2:0]           out_mode_now
);

  localparam int FB = tbmr_pkg::FRAC_BITS;
  localparam int MB = tbmr_pkg::MAG_BITS;
  localparam int RW = tbmr_pkg::RATIO_W;

  logic [15:0] arm_delay_r, idle_timeout_r;
  logic [14:0] step_v_r, step_h_r, lock_dist_r;
  logic [7:0]  rec_frames_r;
  logic [3:0]  replay_ratio_r;

  logic              op_r, pressed_r;
  logic signed [7:0] dx_r, dy_r;
  logic [2:0]        kind_r;
  logic [15:0]       now_r;

  tbmr_pkg::mode_t    mode_r, mode_nxt;
  logic [15:0]        mark_r, mark_nxt;
  logic               layer_r, layer_nxt;
  logic [2:0]         mask_r, mask_nxt;
  logic               recording_r, recording_nxt;
  logic signed [15:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [7:0]         fc_r, fc_nxt;
  logic [15:0]        replay_r, replay_nxt;
  logic               minor_x_r, minor_x_nxt, neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [RW-1:0]      ratio_r, ratio_nxt, racc_r, racc_nxt;
  logic signed [15:0] acc_v_r, acc_v_nxt, acc_h_r, acc_h_nxt, lock_r, lock_nxt;
  logic signed [7:0]  x_r, x_nxt, y_r, y_nxt, h_r, h_nxt, v_r, v_nxt;
  logic [6:0]         mag_r, mag_nxt;
  logic               aneg_r, aneg_nxt, qsel_v_r, qsel_v_nxt;

  logic               ov_r, ov_nxt;
  logic signed [7:0]  ox_r, oy_r, oh_r, ovv_r;
  logic [2:0]         ob_r, om_r;
  logic               ol_r;

  logic               rec_start, rec_on, plan;
  logic signed [16:0] sx17, sy17;
  logic signed [15:0] sx_sat, sy_sat, bx, by;
  logic [7:0]         fc_new;
  logic [14:0]        ax, ay, minor, major;
  logic [19:0]        total;
  logic [31:0]        prod;
  logic [12:0]        scale;
  logic [RW-1:0]      rsum;
  logic               mstep, moving;
  logic [6:0]         xm, ym;
  logic [15:0]        elapsed;
  logic signed [16:0] lock17, a17;
  logic [8:0]         dsum;
  logic signed [15:0] qacc, a_sat;
  logic signed [7:0]  qmot;
  logic [14:0]        qstep, m15, mq, nq;
  logic [6:0]         n7;
  logic [tbmr_pkg::DIV_W-1:0]     quo;
  logic [MB-1:0]                  rem;
  logic                           div_start, div_busy;
  logic [tbmr_pkg::DIV_CNT_W-1:0] div_len;
  logic [tbmr_pkg::DIV_W-1:0]     div_dvd;
  logic [MB-1:0]                  div_dsr;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sd32767;
    end else if (v < -17'sd32767) begin
      return -16'sd32767;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic [14:0] abs15(input logic signed [15:0] v);
    logic [15:0] t;
    t = v[15] ? 16'(-v) : 16'(v);
    return t[14:0];
  endfunction

  tbmr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .len       (div_len),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    rec_start = !recording_r && (dx_r != 8'sd0 || dy_r != 8'sd0);
    rec_on = recording_r || rec_start;
    bx = rec_start ? 16'sd0 : sum_x_r;
    by = rec_start ? 16'sd0 : sum_y_r;
    sx17 = 17'(bx) + 17'(dx_r);
    sy17 = 17'(by) + 17'(dy_r);
    sx_sat = sat16(sx17);
    sy_sat = sat16(sy17);
    fc_new = rec_start ? 8'd1 : 8'(fc_r + 8'd1);
    plan = rec_on && (fc_new >= rec_frames_r);
    ax = abs15(sx_sat);
    ay = abs15(sy_sat);
    total = 20'({1'b0, ax} + {1'b0, ay}) * 20'(replay_ratio_r);
    minor = (ax < ay) ? ax : ay;
    major = (ax < ay) ? ay : ax;

    prod = 32'(replay_r) * 32'(tbmr_pkg::DIV10_MUL);
    scale = 13'(prod >> tbmr_pkg::DIV10_SHIFT) + 13'd1;

    rsum = racc_r + ratio_r;
    mstep = (rsum >= RW'(1 << FB));
    xm = (replay_r != 16'd0 && (!minor_x_r || mstep)) ? mag_r : 7'd0;
    ym = (replay_r != 16'd0 && (minor_x_r || mstep)) ? mag_r : 7'd0;
    moving = (xm != 7'd0) || (ym != 7'd0);
    elapsed = now_r - mark_r;
    dsum = 9'(xm) + 9'(ym);
    lock17 = 17'(lock_r) - 17'(dsum);

    qsel_v_nxt = ({1'b0, ym, 1'b0} > {2'b0, xm});
    qacc = qsel_v_nxt ? acc_v_r : acc_h_r;
    qmot = qsel_v_nxt ? (neg_y_r ? -8'(ym) : 8'(ym)) : (neg_x_r ? -8'(xm) : 8'(xm));
    qstep = qsel_v_nxt ? step_v_r : step_h_r;
    if (qstep == 15'd0) begin
      qstep = 15'd1;
    end
    a17 = 17'(qacc) + 17'(qmot);
    a_sat = sat16(a17);
    m15 = abs15(a_sat);

    nq = quo[MB-1:0];
    n7 = (nq > 15'd127) ? 7'd127 : nq[6:0];
    mq = rem + 15'd1;

    sts.is_key = op_r;
    sts.need_pdiv = plan && (minor != 15'd0);
    sts.need_quant = (mode_r == tbmr_pkg::MODE_SCROLLING) && moving && (m15 > qstep);
    sts.div_busy = div_busy;
    sts.out_busy = ov_r && out_stall;

    div_start = (cmd.rec && sts.need_pdiv) || (cmd.step && sts.need_quant);
    div_len = cmd.rec ? tbmr_pkg::DIV_CNT_W'(tbmr_pkg::DIV_W) : tbmr_pkg::DIV_CNT_W'(MB);
    div_dvd = cmd.rec ? {minor, {FB{1'b0}}} : {15'(m15 - 15'd1), {FB{1'b0}}};
    div_dsr = cmd.rec ? major : qstep;
  end

  always_comb begin
    mode_nxt = mode_r;
    mark_nxt = mark_r;
    layer_nxt = layer_r;
    mask_nxt = mask_r;
    recording_nxt = recording_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    fc_nxt = fc_r;
    replay_nxt = replay_r;
    minor_x_nxt = minor_x_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    ratio_nxt = ratio_r;
    racc_nxt = racc_r;
    acc_v_nxt = acc_v_r;
    acc_h_nxt = acc_h_r;
    lock_nxt = lock_r;
    x_nxt = x_r;
    y_nxt = y_r;
    h_nxt = h_r;
    v_nxt = v_r;
    mag_nxt = mag_r;
    aneg_nxt = aneg_r;
    ov_nxt = ov_r && out_stall;

    if (cmd.key) begin
      x_nxt = '0;
      y_nxt = '0;
      h_nxt = '0;
      v_nxt = '0;
      if (kind_r <= 3'd2) begin
        if (pressed_r) begin
          mask_nxt = mask_r | (3'd1 << kind_r);
          mode_nxt = tbmr_pkg::MODE_CLICKING;
          lock_nxt = 16'(lock_dist_r);
        end else begin
          mask_nxt = mask_r & ~(3'd1 << kind_r);
          layer_nxt = 1'b1;
          mark_nxt = now_r;
          mode_nxt = tbmr_pkg::MODE_CLICKABLE;
        end
      end else if (kind_r == 3'd3) begin
        if (pressed_r) begin
          mode_nxt = tbmr_pkg::MODE_SCROLLING;
        end else begin
          layer_nxt = 1'b1;
          mark_nxt = now_r;
          mode_nxt = tbmr_pkg::MODE_CLICKABLE;
        end
      end else if (pressed_r) begin
        mode_nxt = tbmr_pkg::MODE_IDLE;
        layer_nxt = 1'b0;
        acc_v_nxt = '0;
        acc_h_nxt = '0;
      end
    end

    if (cmd.rec && rec_on) begin
      recording_nxt = 1'b1;
      sum_x_nxt = sx_sat;
      sum_y_nxt = sy_sat;
      fc_nxt = fc_new;
      if (plan) begin
        replay_nxt = (total > 20'd65535) ? 16'hFFFF : total[15:0];
        minor_x_nxt = ax < ay;
        neg_x_nxt = sx_sat[15];
        neg_y_nxt = sy_sat[15];
        ratio_nxt = '0;
        racc_nxt = '0;
        recording_nxt = 1'b0;
        fc_nxt = '0;
      end
    end

    if (cmd.pfin) begin
      ratio_nxt = quo[RW-1:0];
    end

    if (cmd.scale) begin
      mag_nxt = (scale > 13'd127) ? 7'd127 : scale[6:0];
    end

    if (cmd.step) begin
      h_nxt = '0;
      v_nxt = '0;
      x_nxt = neg_x_r ? -8'(xm) : 8'(xm);
      y_nxt = neg_y_r ? -8'(ym) : 8'(ym);
      if (replay_r != 16'd0) begin
        racc_nxt = mstep ? RW'(rsum - RW'(1 << FB)) : rsum;
        replay_nxt = replay_r - 16'd1;
      end
      if (moving) begin
        case (mode_r)
          tbmr_pkg::MODE_CLICKABLE: begin
            mark_nxt = now_r;
          end
          tbmr_pkg::MODE_CLICKING: begin
            lock_nxt = (lock17 < -17'sd32768) ? -16'sd32768 : lock17[15:0];
            if (lock_nxt > 16'sd0) begin
              x_nxt = '0;
              y_nxt = '0;
            end
          end
          tbmr_pkg::MODE_SCROLLING: begin
            x_nxt = '0;
            y_nxt = '0;
            aneg_nxt = a_sat[15];
            if (!sts.need_quant) begin
              if (qsel_v_nxt) begin
                acc_v_nxt = a_sat;
              end else begin
                acc_h_nxt = a_sat;
              end
            end
          end
          tbmr_pkg::MODE_WAITING: begin
            if (elapsed > arm_delay_r) begin
              layer_nxt = 1'b1;
              mark_nxt = now_r;
              mode_nxt = tbmr_pkg::MODE_CLICKABLE;
            end
          end
          default: begin
            mark_nxt = now_r;
            mode_nxt = tbmr_pkg::MODE_WAITING;
          end
        endcase
      end else begin
        case (mode_r)
          tbmr_pkg::MODE_CLICKABLE: begin
            if (elapsed > idle_timeout_r) begin
              mode_nxt = tbmr_pkg::MODE_IDLE;
              layer_nxt = 1'b0;
              acc_v_nxt = '0;
              acc_h_nxt = '0;
            end
          end
          tbmr_pkg::MODE_WAITING: begin
            if (elapsed > tbmr_pkg::WAIT_GIVEUP_MS) begin
              mode_nxt = tbmr_pkg::MODE_IDLE;
            end
          end
          tbmr_pkg::MODE_CLICKING, tbmr_pkg::MODE_SCROLLING: begin
            mode_nxt = mode_r;
          end
          default: begin
            mode_nxt = tbmr_pkg::MODE_IDLE;
          end
        endcase
      end
    end

    if (cmd.qfin) begin
      if (qsel_v_r) begin
        acc_v_nxt = aneg_r ? -16'(mq) : 16'(mq);
        v_nxt = aneg_r ? -8'(n7) : 8'(n7);
      end else begin
        acc_h_nxt = aneg_r ? -16'(mq) : 16'(mq);
        h_nxt = aneg_r ? 8'(n7) : -8'(n7);
      end
    end

    if (cmd.emit) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_delay_r <= 16'd10;
      idle_timeout_r <= 16'd1000;
      step_v_r <= 15'd30;
      step_h_r <= 15'd30;
      rec_frames_r <= 8'd30;
      replay_ratio_r <= 4'd5;
      lock_dist_r <= 15'd30;
      mode_r <= tbmr_pkg::MODE_IDLE;
      mark_r <= '0;
      layer_r <= 1'b0;
      mask_r <= '0;
      recording_r <= 1'b0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      fc_r <= '0;
      replay_r <= '0;
      minor_x_r <= 1'b0;
      neg_x_r <= 1'b0;
      neg_y_r <= 1'b0;
      ratio_r <= '0;
      racc_r <= '0;
      acc_v_r <= '0;
      acc_h_r <= '0;
      lock_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          tbmr_pkg::CFG_ARM_DELAY: arm_delay_r <= cfg_wdata;
          tbmr_pkg::CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
          tbmr_pkg::CFG_SCROLL_V: step_v_r <= cfg_wdata[14:0];
          tbmr_pkg::CFG_SCROLL_H: step_h_r <= cfg_wdata[14:0];
          tbmr_pkg::CFG_REC_FRAMES: rec_frames_r <= cfg_wdata[7:0];
          tbmr_pkg::CFG_REPLAY_RATIO: replay_ratio_r <= cfg_wdata[3:0];
          tbmr_pkg::CFG_LOCK_DIST: lock_dist_r <= cfg_wdata[14:0];
          default: arm_delay_r <= arm_delay_r;
        endcase
      end
      mode_r <= mode_nxt;
      mark_r <= mark_nxt;
      layer_r <= layer_nxt;
      mask_r <= mask_nxt;
      recording_r <= recording_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      fc_r <= fc_nxt;
      replay_r <= replay_nxt;
      minor_x_r <= minor_x_nxt;
      neg_x_r <= neg_x_nxt;
      neg_y_r <= neg_y_nxt;
      ratio_r <= ratio_nxt;
      racc_r <= racc_nxt;
      acc_v_r <= acc_v_nxt;
      acc_h_r <= acc_h_nxt;
      lock_r <= lock_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      dx_r <= in_dx;
      dy_r <= in_dy;
      kind_r <= in_key_kind;
      pressed_r <= in_key_pressed;
      now_r <= in_now_ms;
    end
    if (cmd.step) begin
      qsel_v_r <= qsel_v_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    h_r <= h_nxt;
    v_r <= v_nxt;
    mag_r <= mag_nxt;
    aneg_r <= aneg_nxt;
    if (cmd.emit) begin
      ox_r <= x_r;
      oy_r <= y_r;
      oh_r <= h_r;
      ovv_r <= v_r;
      ob_r <= mask_r;
      ol_r <= layer_r;
      om_r <= mode_r;
    end
  end

  assign out_valid = ov_r;
  assign out_dx = ox_r;
  assign out_dy = oy_r;
  assign out_scroll_h = oh_r;
  assign out_scroll_v = ovv_r;
  assign out_buttons = ob_r;
  assign out_click_layer_active = ol_r;
  assign out_mode_now = om_r;

endmodule

FILE: sv/tbmr_ctrl.sv
module tbmr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tbmr_pkg::status_t         sts,
  output tbmr_pkg::cmd_t            cmd,
  output tbmr_pkg::ctrl_state_t     state
);

  tbmr_pkg::ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbmr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = tbmr_pkg::ST_KEY;
        end
      end
      tbmr_pkg::ST_KEY: begin
        state_nxt = sts.is_key ? tbmr_pkg::ST_OUT : tbmr_pkg::ST_REC;
      end
      tbmr_pkg::ST_REC: begin
        state_nxt = sts.need_pdiv ? tbmr_pkg::ST_PDIV : tbmr_pkg::ST_SCALE;
      end
      tbmr_pkg::ST_PDIV: begin
        if (!sts.div_busy) begin
          state_nxt = tbmr_pkg::ST_SCALE;
        end
      end
      tbmr_pkg::ST_SCALE: begin
        state_nxt = tbmr_pkg::ST_STEP;
      end
      tbmr_pkg::ST_STEP: begin
        state_nxt = sts.need_quant ? tbmr_pkg::ST_QDIV : tbmr_pkg::ST_OUT;
      end
      tbmr_pkg::ST_QDIV: begin
        if (!sts.div_busy) begin
          state_nxt = tbmr_pkg::ST_OUT;
        end
      end
      tbmr_pkg::ST_OUT: begin
        if (!sts.out_busy) begin
          state_nxt = tbmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tbmr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      tbmr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tbmr_pkg::ST_KEY: cmd.key = sts.is_key;
      tbmr_pkg::ST_REC: cmd.rec = 1'b1;
      tbmr_pkg::ST_PDIV: cmd.pfin = !sts.div_busy;
      tbmr_pkg::ST_SCALE: cmd.scale = 1'b1;
      tbmr_pkg::ST_STEP: cmd.step = 1'b1;
      tbmr_pkg::ST_QDIV: cmd.qfin = !sts.div_busy;
      tbmr_pkg::ST_OUT: cmd.emit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbmr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

FILE: sv/trackball_motion_replay_click_layer_top.sv
// Trackball motion replay with a click layer mode machine.
// The input channel carries one word per sensor frame or key event, each with a
// 16-bit millisecond time stamp. Every accepted word yields exactly one result
// word: pointer motion, scroll steps, button mask, layer flag and mode.
// Both channels use valid and stall; the receiver drives stall.
// Items are processed one at a time. A key event passes the key and output
// states. A sensor frame passes the record, scale, step and output states,
// with a ratio division after the record state when a replay plan is made
// with motion on both axes and a quantizing division after the step state
// when a scroll step is due; both divisions share one bit-serial divider.
// The input is stalled while an item is in flight. A finished word sits in the
// output register while the next item is already being accepted and worked on;
// if the receiver still stalls when the next result is ready, the block holds
// that result and stalls the input.
// Configuration writes are taken on cfg_we at any time but are meant for an
// idle block. Synchronous reset loads the default register values, clears the
// control and mode state, not the data registers; no clearing pass is needed.
module trackball_motion_replay_click_layer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [7:0]  in_dx,
  input  logic signed [7:0]  in_dy,
  input  logic [2:0]         in_key_kind,
  input  logic               in_key_pressed,
  input  logic [15:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_dx,
  output logic signed [7:0]  out_dy,
  output logic signed [7:0]  out_scroll_h,
  output logic signed [7:0]  out_scroll_v,
  output logic [2:0]         out_buttons,
  output logic               out_click_layer_active,
  output logic [2:0]         out_mode_now
);

  tbmr_pkg::cmd_t        cmd;
  tbmr_pkg::status_t     sts;
  tbmr_pkg::ctrl_state_t state;

  tbmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  tbmr_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_idx                (cfg_idx),
    .cfg_wdata              (cfg_wdata),
    .in_opcode              (in_opcode),
    .in_dx                  (in_dx),
    .in_dy                  (in_dy),
    .in_key_kind            (in_key_kind),
    .in_key_pressed         (in_key_pressed),
    .in_now_ms              (in_now_ms),
    .out_stall              (out_stall),
    .out_valid              (out_valid),
    .out_dx                 (out_dx),
    .out_dy                 (out_dy),
    .out_scroll_h           (out_scroll_h),
    .out_scroll_v           (out_scroll_v),
    .out_buttons            (out_buttons),
    .out_click_layer_active (out_click_layer_active),
    .out_mode_now           (out_mode_now)
  );

  a_accept_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !sts.div_busy)
    else $error("Input word accepted while the divider is running.");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state) == tbmr_pkg::ST_OUT)
    else $error("Result word appeared outside the output state.");

  a_layer_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_click_layer_active) |->
      (out_mode_now != tbmr_pkg::MODE_IDLE && out_mode_now != tbmr_pkg::MODE_WAITING))
    else $error("Click layer reported on while the mode is idle or waiting.");

endmodule
